@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the hash core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

// Property checked at every rising edge outside reset.
`define ASSERT_NORST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`endif

@@ hdl/mh64_pkg.sv @@
// Package for the 64-bit byte hash core: constants, item codes and types.
// No dependencies.
package mh64_pkg;

  localparam logic [63:0] SEED_RESET = 64'h1234567890ABCDEF;
  localparam logic [63:0] MIX_C1     = 64'h87c37b91114253d5;
  localparam logic [63:0] MIX_C2     = 64'h4cf5ad432745937f;
  localparam logic [63:0] CHAIN_ADD  = 64'h0000000052dce729;
  localparam logic [63:0] FMIX_M1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_M2    = 64'hc4ceb9fe1a85ec53;

  localparam int PADDR_W = 1;
  localparam logic [PADDR_W-1:0] ADDR_SEED = 1'b0;

  localparam logic [1:0] OP_BYTE      = 2'd0;
  localparam logic [1:0] OP_BYTE_LAST = 2'd1;
  localparam logic [1:0] OP_FINISH    = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic [7:0] data_byte;
  } head_t;

  function automatic logic [63:0] shift_xor(input logic [63:0] x);
    shift_xor = x ^ (x >> 33);
  endfunction

endpackage

@@ hdl/murmur_style_byte_hash64_core.sv @@
// Top level of the streaming 64-bit byte hash core with its configuration port.
// Depends on mh64_pkg, mh64_front and mh64_back.
//
// Input channel: one message byte per beat (data_byte, has_byte, last), taken
// when push is high and full is low. Beats with neither a byte nor last are
// dropped. A queue of QUEUE_DEPTH entries in the front end feeds the back
// end, so input keeps flowing while the back end works.
// Result channel: one digest per message, shown while empty is low and taken
// when pop is high.
// The back end mixes each byte through the shared multicycle 64-bit
// multiplier. Finalizing makes two more passes through that multiplier plus
// setup and result load; an end marker without a byte starts the first pass
// at once, with no separate setup step.
// Reset empties the queue and the result register and loads the seed
// register and the chain value with the default seed.
// When the result register is held, the back end waits with the digest and
// the queue absorbs input until full rises.
// The seed register is written through the APB port at address 0.
module murmur_style_byte_hash64_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   data_byte,
  input  logic                         has_byte,
  input  logic                         last,
  output logic                         empty,
  input  logic                         pop,
  output logic [63:0]                  digest,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mh64_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import mh64_pkg::*;

  head_t       head;
  logic        head_pop;
  logic        seed_we;
  logic [63:0] seed;
  logic        out_valid;

  assign pready  = 1'b1;
  assign seed_we = psel && penable && pwrite && (paddr == ADDR_SEED);
  assign prdata  = (paddr == ADDR_SEED) ? seed : '0;
  assign empty   = !out_valid;

  mh64_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .last      (last),
    .full      (full),
    .head      (head),
    .head_pop  (head_pop)
  );

  mh64_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_pop   (head_pop),
    .seed_we    (seed_we),
    .seed_wdata (pwdata),
    .seed       (seed),
    .out_valid  (out_valid),
    .digest     (digest),
    .pop        (pop)
  );

endmodule

@@ hdl/mh64_front.sv @@
// Front end of the hash core: accepts input beats, classifies them and queues them.
// Depends on mh64_pkg.
module mh64_front #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [7:0]     data_byte,
  input  logic           has_byte,
  input  logic           last,
  output logic           full,
  output mh64_pkg::head_t head,
  input  logic           head_pop
);
  import mh64_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [1:0]       op_mem [QUEUE_DEPTH];
  logic [7:0]       byte_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       op_in;
  logic             wr_en;
  logic             rd_en;

  // Items with neither a byte nor an end mark change nothing and are dropped here.
  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign wr_en = push && !full && (has_byte || last);
  assign rd_en = head_pop && (count != '0);
  assign op_in = has_byte ? (last ? OP_BYTE_LAST : OP_BYTE) : OP_FINISH;

  assign head.valid     = (count != '0);
  assign head.op        = op_mem[rd_ptr];
  assign head.data_byte = byte_mem[rd_ptr];

  always_comb begin
    unique case ({wr_en, rd_en})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      op_mem[wr_ptr]   <= op_in;
      byte_mem[wr_ptr] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

endmodule

@@ hdl/mh64_mul.sv @@
// Multicycle 64 by 64 multiplier keeping the low 64 bits, one 32x32 product a cycle.
// Depends on mh64_pkg.
module mh64_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] product
);
  import mh64_pkg::*;

  logic [63:0] a_q;
  logic [63:0] b_q;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [1:0]  step;
  logic        run;
  logic [31:0] ma;
  logic [31:0] mb;

  assign product = acc;

  always_comb begin
    unique case (step)
      2'd0:    begin ma = a_q[31:0];  mb = b_q[31:0];  end
      2'd1:    begin ma = a_q[31:0];  mb = b_q[63:32]; end
      default: begin ma = a_q[63:32]; mb = b_q[31:0];  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
    end
    if (run) begin
      prod <= 64'(ma) * 64'(mb);
      unique case (step)
        2'd0:    acc <= acc;
        2'd1:    acc <= prod;
        default: acc <= acc + {prod[31:0], 32'b0};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (run) begin
      step <= step + 1'b1;
      if (step == 2'd3) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

@@ hdl/mh64_back.sv @@
// Back end of the hash core: byte mixing, chain update, finalizer and result register.
// Depends on mh64_pkg and mh64_mul.
module mh64_back (
  input  logic            clk,
  input  logic            rst,
  input  mh64_pkg::head_t head,
  output logic            head_pop,
  input  logic            seed_we,
  input  logic [63:0]     seed_wdata,
  output logic [63:0]     seed,
  output logic            out_valid,
  output logic [63:0]     digest,
  input  logic            pop
);
  import mh64_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KMUL = 3'd1;
  localparam logic [2:0] S_FIN0 = 3'd2;
  localparam logic [2:0] S_FIN1 = 3'd3;
  localparam logic [2:0] S_FIN2 = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state;
  logic [63:0] chain;
  logic [63:0] byte_count;
  logic        is_last;
  logic [63:0] hash_hold;
  logic        out_load;
  logic        mul_start;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_p;
  logic [63:0] k_prod;
  logic [63:0] k_rot;
  logic [63:0] chain_mix;
  logic [63:0] chain_rot;
  logic [63:0] chain_upd;
  logic [63:0] fin_x;

  mh64_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  assign k_prod    = 64'(head.data_byte) * MIX_C1;
  assign k_rot     = {k_prod[32:0], k_prod[63:33]};
  assign chain_mix = chain ^ mul_p;
  assign chain_rot = {chain_mix[36:0], chain_mix[63:37]};
  assign chain_upd = chain_rot + {chain_rot[61:0], 2'b00} + CHAIN_ADD;
  assign fin_x     = chain ^ byte_count;
  assign out_load  = (state == S_OUT) && (!out_valid || pop);

  always_comb begin
    head_pop  = 1'b0;
    mul_start = 1'b0;
    mul_a     = k_rot;
    mul_b     = MIX_C2;
    unique case (state)
      S_IDLE: begin
        if (head.valid) begin
          head_pop  = 1'b1;
          mul_start = 1'b1;
          if (head.op == OP_FINISH) begin
            mul_a = shift_xor(fin_x);
            mul_b = FMIX_M1;
          end
        end
      end
      S_FIN0: begin
        mul_start = 1'b1;
        mul_a     = shift_xor(fin_x);
        mul_b     = FMIX_M1;
      end
      S_FIN1: begin
        mul_start = mul_done;
        mul_a     = shift_xor(mul_p);
        mul_b     = FMIX_M2;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN2 && mul_done) begin
      hash_hold <= shift_xor(mul_p);
    end
    if (out_load) begin
      digest <= hash_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seed       <= SEED_RESET;
      chain      <= SEED_RESET;
      byte_count <= '0;
      is_last    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            if (head.op == OP_FINISH) begin
              chain      <= seed;
              byte_count <= '0;
              state      <= S_FIN1;
            end else begin
              is_last <= (head.op == OP_BYTE_LAST);
              state   <= S_KMUL;
            end
          end
        end
        S_KMUL: begin
          if (mul_done) begin
            chain      <= chain_upd;
            byte_count <= byte_count + 1'b1;
            state      <= is_last ? S_FIN0 : S_IDLE;
          end
        end
        S_FIN0: begin
          chain      <= seed;
          byte_count <= '0;
          state      <= S_FIN1;
        end
        S_FIN1: begin
          if (mul_done) begin
            state <= S_FIN2;
          end
        end
        S_FIN2: begin
          if (mul_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      // A new seed restarts the chain only between messages.
      if (seed_we) begin
        seed <= seed_wdata;
        if (byte_count == '0) begin
          chain <= seed_wdata;
        end
      end
    end
  end

endmodule

@@ hdl/mh64_checker.sv @@
// Port-level checks for the hash core, attached to the top level by bind.
// Depends on mh64_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mh64_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [63:0]                  digest,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [mh64_pkg::PADDR_W-1:0] paddr,
  input logic [63:0]                  pwdata,
  input logic [63:0]                  prdata,
  input logic                         pready
);
  import mh64_pkg::*;

  logic seed_write;

  assign seed_write = psel && penable && pwrite && pready && (paddr == ADDR_SEED);

  // Reset leaves no result and a queue with room.
  `ASSERT_ALWAYS(a_reset_clear, clk, rst |=> (empty && !full))
  // A waiting result beat holds until it is taken.
  `ASSERT_NORST(a_result_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(digest)))
  // A seed write is read back on the next cycle.
  `ASSERT_NORST(a_seed_readback, clk, rst,
    seed_write |=> ((paddr != ADDR_SEED) || (prdata == $past(pwdata))))
  // A waiting result does not vanish while the receiver has not popped it.
  `ASSERT_NORST(a_no_lost_result, clk, rst, (!empty && !pop) |=> !empty)

endmodule

bind murmur_style_byte_hash64_core mh64_checker u_checker (.*);

@@ sim/tb_murmur_style_byte_hash64_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for murmur_style_byte_hash64_core: byte beats in, digests out,
// seed written over APB. Checks against a local hash model; depends on mh64_pkg and the core.
module tb_murmur_style_byte_hash64_core;
  import mh64_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int ITEMS_PER_PHASE = 480;

  typedef enum logic [0:0] {ROW_BEAT, ROW_SEED} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [63:0] value;
    logic        has;
    logic        lst;
    logic        known;
    logic [63:0] known_digest;
  } dir_row_t;

  localparam int N_ROWS = 22;
  localparam dir_row_t DIRECTED [N_ROWS] = '{
    '{ROW_BEAT, 64'hA5, 1'b0, 1'b1, 1'b0, 64'h0},
    '{ROW_BEAT, 64'h00, 1'b1, 1'b1, 1'b0, 64'h0},
    '{ROW_BEAT, 64'hFF, 1'b1, 1'b1, 1'b0, 64'h0},
    '{ROW_BEAT, 64'h5A, 1'b0, 1'b0, 1'b0, 64'h0},
    '{ROW_BEAT, 64'h01, 1'b1, 1'b0, 1'b0, 64'h0},
    '{ROW_BEAT, 64'h80, 1'b1, 1'b0, 1'b0, 64'h0},
    '{ROW_BEAT, 64'hC3, 1'b0, 1'b0, 1'b0, 64'h0},
    '{ROW_BEAT, 64'h7F, 1'b1, 1'b0, 1'b0, 64'h0},
    '{ROW_BEAT, 64'h3C, 1'b0, 1'b1, 1'b0, 64'h0},
    '{ROW_SEED, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0},
    '{ROW_BEAT, 64'hFF, 1'b0, 1'b1, 1'b1, 64'h0},
    '{ROW_SEED, 64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0, 1'b0, 64'h0},
    '{ROW_BEAT, 64'hFF, 1'b1, 1'b0, 1'b0, 64'h0},
    '{ROW_BEAT, 64'hFF, 1'b1, 1'b1, 1'b0, 64'h0},
    '{ROW_BEAT, 64'h10, 1'b1, 1'b0, 1'b0, 64'h0},
    '{ROW_BEAT, 64'h20, 1'b1, 1'b0, 1'b0, 64'h0},
    '{ROW_SEED, 64'h0123456789ABCDEF, 1'b0, 1'b0, 1'b0, 64'h0},
    '{ROW_BEAT, 64'h30, 1'b1, 1'b1, 1'b0, 64'h0},
    '{ROW_BEAT, 64'h00, 1'b0, 1'b1, 1'b0, 64'h0},
    '{ROW_SEED, SEED_RESET, 1'b0, 1'b0, 1'b0, 64'h0},
    '{ROW_BEAT, 64'h00, 1'b0, 1'b1, 1'b0, 64'h0},
    '{ROW_BEAT, 64'h00, 1'b0, 1'b0, 1'b0, 64'h0}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [7:0]          data_byte = 8'h00;
  logic                has_byte = 1'b0;
  logic                last = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic [63:0]         digest;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = ADDR_SEED;
  logic [63:0]         pwdata = 64'h0;
  logic [63:0]         prdata;
  logic                pready;

  logic [63:0] model_seed = SEED_RESET;
  logic [63:0] model_chain = SEED_RESET;
  logic [63:0] model_count = 64'h0;

  logic [63:0] expected_digests [$];
  logic [63:0] oldest_digest;
  int          fail_count = 0;
  int          items_sent = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;

  murmur_style_byte_hash64_core i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .data_byte(data_byte), .has_byte(has_byte), .last(last),
    .empty(empty), .pop(pop), .digest(digest),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] rotate_left(input logic [63:0] x, input int r);
    rotate_left = (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] finalize_mix(input logic [63:0] x);
    logic [63:0] v;
    v = x ^ (x >> 33);
    v = v * FMIX_M1;
    v = v ^ (v >> 33);
    v = v * FMIX_M2;
    finalize_mix = v ^ (v >> 33);
  endfunction

  // Advances the hash state by one beat; returns 1 when the beat closes a message.
  function automatic bit hash_beat(input logic [7:0] b, input logic hb, input logic lst,
                                   output logic [63:0] dg);
    logic [63:0] k;
    dg = 64'h0;
    if (hb) begin
      k = {56'h0, b} * MIX_C1;
      k = rotate_left(k, 31);
      k = k * MIX_C2;
      model_chain = rotate_left(model_chain ^ k, 27);
      model_chain = model_chain * 64'd5 + CHAIN_ADD;
      model_count = model_count + 64'd1;
    end
    if (!lst) return 1'b0;
    dg = finalize_mix(model_chain ^ model_count);
    model_chain = model_seed;
    model_count = 64'h0;
    return 1'b1;
  endfunction

  task automatic issue_beat(input logic [7:0] b, input logic hb, input logic lst,
                            input logic use_known, input logic [63:0] known);
    logic [63:0] dg;
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    has_byte <= hb;
    last <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
    if (hash_beat(b, hb, lst, dg)) expected_digests.push_back(use_known ? known : dg);
    if (hb || lst) items_sent++;
  endtask

  // Lets the core drain completely, then writes the seed and reads it back.
  task automatic write_seed(input logic [63:0] value);
    push <= 1'b0;
    while (expected_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SEED;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    model_seed = value;
    if (model_count == 64'h0) model_chain = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== model_seed) begin
      $error("prdata mismatch: expected %h, actual %h", model_seed, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_message();
    int len;
    bit byte_ends;
    len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
    byte_ends = (len > 0) && $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) issue_beat(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 64'h0);
      if ($urandom_range(199) == 0) write_seed({$urandom, $urandom});
      issue_beat(8'($urandom_range(255)), 1'b1, byte_ends && (i == len - 1), 1'b0, 64'h0);
    end
    if (!byte_ends) issue_beat(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, 64'h0);
    if ($urandom_range(99) < 3) write_seed({$urandom, $urandom});
  endtask

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= receiver_stall_pct);
    if (!rst && pop && !empty) begin
      if (expected_digests.size() == 0) begin
        $error("digest mismatch: expected none, actual %h", digest);
        fail_count++;
      end else begin
        oldest_digest = expected_digests.pop_front();
        if (digest !== oldest_digest) begin
          $error("digest mismatch: expected %h, actual %h", oldest_digest, digest);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [63:0] phase_seed [4];
    int target;
    phase_seed[0] = 64'h0;
    phase_seed[1] = 64'hFFFFFFFFFFFFFFFF;
    phase_seed[2] = {$urandom, $urandom};
    phase_seed[3] = SEED_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_SEED) write_seed(DIRECTED[r].value);
      else issue_beat(DIRECTED[r].value[7:0], DIRECTED[r].has, DIRECTED[r].lst,
                      DIRECTED[r].known, DIRECTED[r].known_digest);
    end

    for (int p = 0; p < 4; p++) begin
      write_seed(phase_seed[p]);
      case (p)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 86;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 86;
        end
        default: begin
          sender_idle_pct = 30;
          receiver_stall_pct = 30;
        end
      endcase
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) random_message();
    end

    push <= 1'b0;
    while (expected_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("murmur_style_byte_hash64_core verification clean");
    end else begin
      $display("murmur_style_byte_hash64_core verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("murmur_style_byte_hash64_core verification failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/mh64_pkg.sv
hdl/mh64_front.sv
hdl/mh64_mul.sv
hdl/mh64_back.sv
hdl/murmur_style_byte_hash64_core.sv
hdl/mh64_checker.sv
sim/tb_murmur_style_byte_hash64_core.sv
